// ===== sv/aef_pkg.sv =====
// ----------------------------------------------------------------------------
// aef_pkg
// Shared types, constants and helpers of the alpha edge feather block.
// ----------------------------------------------------------------------------
package aef_pkg;

	// configuration port
	localparam int SIDE_W    = 13;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;
	localparam int CANVAS_RST = 64;

	// stream payload
	localparam int CHAN_W = 8;
	localparam int DATA_W = 4 * CHAN_W;

	// parameter defaults
	localparam int MAX_SIDE_DEF      = 4096;
	localparam int FRACTION_BITS_DEF = 16;

	// feather span: round(0.055 * side) clamped to SPAN_LOW..SPAN_HIGH
	localparam int SPAN_W        = 5;
	localparam int SPAN_LOW      = 6;
	localparam int SPAN_HIGH     = 28;
	localparam int SPAN_MUL      = 55;
	localparam int SPAN_BIAS     = 500;
	localparam int SPAN_DIV      = 1000;
	// sides at or above this cap all clamp to SPAN_HIGH
	localparam int SPAN_SIDE_CAP = 520;
	localparam int SPAN_CAP_W    = 10;
	localparam int SPAN_NUM_W    = 15;
	// n / 1000 == (n * 4195) >> 22 for every n the capped side can produce
	localparam int SPAN_RECIP    = 4195;
	localparam int SPAN_RECIP_W  = 13;
	localparam int SPAN_SHIFT    = 22;

	// datapath step codes
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_NONE  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_RECIP = 3'd1;
	localparam logic [STEP_W-1:0] STEP_QSPAN = 3'd2;
	localparam logic [STEP_W-1:0] STEP_FIX   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_SQ    = 3'd4;
	localparam logic [STEP_W-1:0] STEP_CUBE  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_SCALE = 3'd6;

	typedef struct packed {
		logic              load;
		logic              push;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic feather;
	} sts_t;

	// zero acts as one, anything above the maximum side acts as the maximum
	function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] raw,
	                                               input int unsigned max_side);
		logic [SIDE_W-1:0] res;
		res = raw;
		if (raw == '0)
			res = SIDE_W'(1);
		else if ({19'd0, raw} > max_side)
			res = max_side[SIDE_W-1:0];
		return res;
	endfunction

endpackage

// ===== sv/alpha_edge_feather.sv =====
// ----------------------------------------------------------------------------
// alpha_edge_feather
// Smoothstep feathering of the alpha channel near the canvas border.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata take BGRA pixels of the canvas in raster order.
//   m_tvalid/m_tready/m_tdata return the same pixel with alpha attenuated by
//   smoothstep(distance / span) inside the border band; m_tlast marks the
//   last pixel of the canvas. One result per pixel, in order.
//   cfg_wen/cfg_index/cfg_wdata write canvas width (0) or height (1); any
//   write recomputes the feather span and restarts the frame at pixel 0.
//   Write only while no pixel is in flight.
// Timing:
//   One pixel is in work at a time. Pixels outside the band go from accept
//   straight to the hand-off to the output register; pixels inside the band
//   first pass six datapath steps (reciprocal estimate, multiply-back,
//   correction, square, cubic term, alpha scale), five of them through the
//   one shared multiplier.
// Reset: canvas 64 x 64, span 6, counters at zero, output empty.
// Stall: the output register holds a result while m_tready is low; the next
//   pixel is still computed and waits for the register to free up.
// ----------------------------------------------------------------------------
module alpha_edge_feather #(
	parameter int MAX_SIDE      = aef_pkg::MAX_SIDE_DEF,
	parameter int FRACTION_BITS = aef_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [aef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aef_pkg::SIDE_W-1:0]    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [aef_pkg::DATA_W-1:0]    s_tdata,  // blue_in, green_in, red_in, alpha_in
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [aef_pkg::DATA_W-1:0]    m_tdata,  // blue_out, green_out, red_out, alpha_out
	output logic                          m_tlast   // frame_end
);
	import aef_pkg::*;

	cmd_t cmd;
	sts_t sts;

	aef_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	aef_dpath #(
		.MAX_SIDE      (MAX_SIDE),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== sv/aef_ctrl.sv =====
// ----------------------------------------------------------------------------
// aef_ctrl
// Sequencer: accepts a pixel, steps the datapath through the feather
// arithmetic when needed, and hands the result to the output register.
// ----------------------------------------------------------------------------
module aef_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  aef_pkg::sts_t sts,
	output aef_pkg::cmd_t cmd
);
	import aef_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RECIP = 3'd1;
	localparam logic [2:0] ST_QSPAN = 3'd2;
	localparam logic [2:0] ST_FIX   = 3'd3;
	localparam logic [2:0] ST_SQ    = 3'd4;
	localparam logic [2:0] ST_CUBE  = 3'd5;
	localparam logic [2:0] ST_SCALE = 3'd6;
	localparam logic [2:0] ST_PUSH  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd.load  = 1'b0;
		cmd.push  = 1'b0;
		cmd.step  = STEP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = sts.feather ? ST_RECIP : ST_PUSH;
				end
			end
			ST_RECIP: begin
				cmd.step  = STEP_RECIP;
				state_nxt = ST_QSPAN;
			end
			ST_QSPAN: begin
				cmd.step  = STEP_QSPAN;
				state_nxt = ST_FIX;
			end
			ST_FIX: begin
				cmd.step  = STEP_FIX;
				state_nxt = ST_SQ;
			end
			ST_SQ: begin
				cmd.step  = STEP_SQ;
				state_nxt = ST_CUBE;
			end
			ST_CUBE: begin
				cmd.step  = STEP_CUBE;
				state_nxt = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.step  = STEP_SCALE;
				state_nxt = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) begin
					cmd.push  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/aef_dpath.sv =====
// ----------------------------------------------------------------------------
// aef_dpath
// Canvas registers, position counters, edge distance, the shared multiplier
// for the smoothstep arithmetic, and the output register.
// ----------------------------------------------------------------------------
module aef_dpath #(
	parameter int MAX_SIDE      = aef_pkg::MAX_SIDE_DEF,
	parameter int FRACTION_BITS = aef_pkg::FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [aef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aef_pkg::SIDE_W-1:0]    cfg_wdata,
	input  logic [aef_pkg::DATA_W-1:0]    s_tdata,
	output logic [aef_pkg::DATA_W-1:0]    m_tdata,
	output logic                         m_tlast,
	input  aef_pkg::cmd_t                cmd,
	output aef_pkg::sts_t                sts
);
	import aef_pkg::*;

	localparam int F     = FRACTION_BITS;
	localparam int CNT_W = ($clog2(MAX_SIDE) < SIDE_W) ? $clog2(MAX_SIDE) : SIDE_W;
	localparam int R_W   = F + 3;
	localparam int A_W   = F + 3;
	localparam int B_W   = F + 2;
	localparam int P_W   = A_W + B_W;
	localparam int N_W   = F + SPAN_W;
	localparam int H_W   = SPAN_W - 1;

	localparam int RST_SIDE = (CANVAS_RST > MAX_SIDE) ? MAX_SIDE : CANVAS_RST;
	localparam int RST_RAW  = (RST_SIDE * SPAN_MUL + SPAN_BIAS) / SPAN_DIV;
	localparam int RST_SPAN = (RST_RAW < SPAN_LOW) ? SPAN_LOW :
	                          (RST_RAW > SPAN_HIGH) ? SPAN_HIGH : RST_RAW;

	localparam logic [P_W-1:0] HALF   = P_W'(1) << (F - 1);
	localparam logic [F:0]     ONE    = (F + 1)'(1) << F;
	localparam logic [B_W-1:0] THREE1 = B_W'(3) << F;

	// reciprocal table: floor(2^(F+5) / span)
	logic [R_W-1:0] recip_tab [SPAN_LOW:SPAN_HIGH];
	for (genvar s = SPAN_LOW; s <= SPAN_HIGH; s++) begin : g_recip
		localparam longint RV = (64'd1 << (F + 5)) / s;
		assign recip_tab[s] = R_W'(RV);
	end

	// configuration and frame state
	logic [SIDE_W-1:0] width_q, height_q;
	logic [SPAN_W-1:0] span_q;
	logic [CNT_W-1:0]  col_q, row_q;

	// pixel in work
	logic [CHAN_W-1:0] blue_q, green_q, red_q, alpha_q;
	logic [CHAN_W-1:0] alpha_res_q;
	logic              last_q;
	logic [SPAN_W-1:0] d_q;
	logic [R_W-1:0]    r_q;
	logic [P_W-1:0]    acc_q;
	logic [F-1:0]      q_q, p_q, sq_q;
	logic [F:0]        s_q;

	// ---- span derivation on a size write ----
	logic [SIDE_W-1:0]       new_w, new_h, min_side;
	logic [SPAN_CAP_W-1:0]   cap_side;
	logic [SPAN_NUM_W-1:0]   span_num;
	logic [SPAN_NUM_W+SPAN_RECIP_W-1:0] span_prod;
	logic [SPAN_W-1:0]       span_raw, span_new;

	always_comb begin
		new_w = (cfg_index == REG_CANVAS_WIDTH) ? eff_side(cfg_wdata, MAX_SIDE) : width_q;
		new_h = (cfg_index == REG_CANVAS_HEIGHT) ? eff_side(cfg_wdata, MAX_SIDE) : height_q;
		min_side = (new_w < new_h) ? new_w : new_h;
		cap_side = (min_side > SIDE_W'(SPAN_SIDE_CAP)) ? SPAN_CAP_W'(SPAN_SIDE_CAP)
		                                               : min_side[SPAN_CAP_W-1:0];
		span_num  = SPAN_NUM_W'(cap_side * SPAN_NUM_W'(SPAN_MUL)) + SPAN_NUM_W'(SPAN_BIAS);
		span_prod = span_num * SPAN_RECIP_W'(SPAN_RECIP);
		span_raw  = span_prod[SPAN_SHIFT +: SPAN_W];
		if (span_raw < SPAN_W'(SPAN_LOW))
			span_new = SPAN_W'(SPAN_LOW);
		else if (span_raw > SPAN_W'(SPAN_HIGH))
			span_new = SPAN_W'(SPAN_HIGH);
		else
			span_new = span_raw;
	end

	// ---- edge distance of the current position ----
	logic [SIDE_W-1:0] x_ext, y_ext, dx, dy, edge_dist;
	logic              col_end, row_end;

	always_comb begin
		x_ext   = SIDE_W'(col_q);
		y_ext   = SIDE_W'(row_q);
		dx      = width_q - SIDE_W'(1) - x_ext;
		dy      = height_q - SIDE_W'(1) - y_ext;
		edge_dist = x_ext;
		if (dx < edge_dist)
			edge_dist = dx;
		if (y_ext < edge_dist)
			edge_dist = y_ext;
		if (dy < edge_dist)
			edge_dist = dy;
		col_end = (x_ext == width_q - SIDE_W'(1));
		row_end = (y_ext == height_q - SIDE_W'(1));
	end

	assign sts.feather = (edge_dist < SIDE_W'(span_q));

	// ---- shared multiplier ----
	logic [A_W-1:0]   mul_a;
	logic [B_W-1:0]   mul_b;
	logic [P_W-1:0]   mul_p;
	logic [H_W-1:0]   half_span;
	logic [F+H_W+R_W-1:0] hr;
	logic [P_W-1:0]   rnd;
	logic [P_W-F-1:0] rnd_sh;
	logic [F-1:0]     q0;
	logic [N_W-1:0]   num, rem;

	assign half_span = span_q[SPAN_W-1:1];
	assign hr        = (F + H_W + R_W)'(half_span * r_q);
	assign q0        = acc_q[F + 5 +: F];
	assign num       = {d_q, F'(half_span)};
	assign rem       = num - acc_q[N_W-1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			STEP_RECIP: begin
				mul_a = r_q;
				mul_b = B_W'(d_q);
			end
			STEP_QSPAN: begin
				mul_a = A_W'(q0);
				mul_b = B_W'(span_q);
			end
			STEP_SQ: begin
				mul_a = A_W'(p_q);
				mul_b = B_W'(p_q);
			end
			STEP_CUBE: begin
				mul_a = A_W'(sq_q);
				mul_b = THREE1 - B_W'({p_q, 1'b0});
			end
			STEP_SCALE: begin
				mul_a = A_W'(s_q);
				mul_b = B_W'(alpha_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign rnd    = mul_p + HALF;
	assign rnd_sh = rnd[P_W-1:F];

	// ---- control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(RST_SIDE);
			height_q <= SIDE_W'(RST_SIDE);
			span_q   <= SPAN_W'(RST_SPAN);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wen) begin
			width_q  <= new_w;
			height_q <= new_h;
			span_q   <= span_new;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cmd.load) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// ---- payload ----
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			blue_q      <= s_tdata[0*CHAN_W +: CHAN_W];
			green_q     <= s_tdata[1*CHAN_W +: CHAN_W];
			red_q       <= s_tdata[2*CHAN_W +: CHAN_W];
			alpha_q     <= s_tdata[3*CHAN_W +: CHAN_W];
			alpha_res_q <= s_tdata[3*CHAN_W +: CHAN_W];
			last_q      <= col_end && row_end;
			d_q         <= edge_dist[SPAN_W-1:0];
			r_q         <= recip_tab[span_q];
		end
		case (cmd.step)
			STEP_RECIP: acc_q <= {mul_p[F+4:0], F'(0)} + P_W'(hr);
			STEP_QSPAN: begin
				q_q   <= q0;
				acc_q <= mul_p;
			end
			// quotient estimate is exact or one low
			STEP_FIX:   p_q <= q_q + F'(rem >= N_W'(span_q));
			STEP_SQ:    sq_q <= rnd_sh[F-1:0];
			STEP_CUBE:  s_q <= ((P_W - F)'(ONE) < rnd_sh) ? ONE : rnd_sh[F:0];
			STEP_SCALE: alpha_res_q <= ((P_W - F)'(8'hFF) < rnd_sh) ? 8'hFF
			                                                       : rnd_sh[CHAN_W-1:0];
			default: ;
		endcase
		if (cmd.push) begin
			m_tdata <= {alpha_res_q, red_q, green_q, blue_q};
			m_tlast <= last_q;
		end
	end

endmodule

// ===== sv/aef_checker.sv =====
// ----------------------------------------------------------------------------
// aef_checker
// Port-level checks of the alpha edge feather block, bound to the top level.
// ----------------------------------------------------------------------------
module aef_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [aef_pkg::DATA_W-1:0] m_tdata,
	input logic                       m_tlast
);
	import aef_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// one pixel in work at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	// a new result only comes from a pixel in work
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result with no pixel in work");

	// the last pixel is a corner, so its alpha is fully faded
	a_corner_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[3*CHAN_W +: CHAN_W] == '0)
		else $error("corner pixel kept alpha");

endmodule

bind alpha_edge_feather aef_checker u_aef_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/alpha_edge_feather_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alpha_edge_feather_test
// Self-checking bench for the smoothstep alpha edge feather block.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order over a series of canvas sizes. These
// include zero and oversize register values, one-pixel canvases and restarts
// in the middle of a frame. Both stream sides idle at random. A scoreboard
// tracks the raster position and the feather span. For each accepted request
// it predicts the output pixel, then compares every returned pixel field by
// field.
// ----------------------------------------------------------------------------
module alpha_edge_feather_test;
	import aef_pkg::*;

	localparam int FB = FRACTION_BITS_DEF;

	typedef struct {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] alpha;
		logic              frame_end;
	} pixel_t;

	class feather_scoreboard;
		logic [SIDE_W-1:0] width_reg;
		logic [SIDE_W-1:0] height_reg;
		int unsigned       col;
		int unsigned       row;
		int unsigned       span;
		pixel_t            pending[$];
		int                mismatches;
		int                frame_ends;
		int                pixels_done;

		function new();
			width_reg   = SIDE_W'(CANVAS_RST);
			height_reg  = SIDE_W'(CANVAS_RST);
			mismatches  = 0;
			frame_ends  = 0;
			pixels_done = 0;
			restart();
		endfunction

		static function int unsigned clip_side(logic [SIDE_W-1:0] raw);
			if (raw == '0)
				return 1;
			if (raw > MAX_SIDE_DEF)
				return MAX_SIDE_DEF;
			return 32'(raw);
		endfunction

		// new span from the shorter side, raster position back to pixel 0
		function void restart();
			int unsigned w, h, m, s;
			w = clip_side(width_reg);
			h = clip_side(height_reg);
			m = (w < h) ? w : h;
			s = (m * SPAN_MUL + SPAN_BIAS) / SPAN_DIV;
			if (s < SPAN_LOW)
				s = SPAN_LOW;
			if (s > SPAN_HIGH)
				s = SPAN_HIGH;
			span = s;
			col  = 0;
			row  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
			if (idx == REG_CANVAS_WIDTH)
				width_reg = val;
			else
				height_reg = val;
			restart();
		endfunction

		static function logic [CHAN_W-1:0] feathered_alpha(logic [CHAN_W-1:0] a,
		                                                    int unsigned d,
		                                                    int unsigned span_q);
			longint unsigned one, half, p, p2, s, r;
			one  = 64'd1 << FB;
			half = one >> 1;
			p    = ((64'(d) << FB) + 64'(span_q / 2)) / 64'(span_q);
			p2   = (p * p + half) >> FB;
			s    = (p2 * (3 * one - 2 * p) + half) >> FB;
			if (s > one)
				s = one;
			r = (64'(a) * s + half) >> FB;
			if (r > 255)
				r = 255;
			return r[CHAN_W-1:0];
		endfunction

		function void accept_pixel(logic [DATA_W-1:0] px);
			int unsigned w, h, x, y, d;
			pixel_t      e;
			w = clip_side(width_reg);
			h = clip_side(height_reg);
			x = (col >= w) ? w - 1 : col;
			y = (row >= h) ? h - 1 : row;
			// distance to the nearest border
			d = x;
			if (w - 1 - x < d)
				d = w - 1 - x;
			if (y < d)
				d = y;
			if (h - 1 - y < d)
				d = h - 1 - y;
			e.blue  = px[0*CHAN_W +: CHAN_W];
			e.green = px[1*CHAN_W +: CHAN_W];
			e.red   = px[2*CHAN_W +: CHAN_W];
			e.alpha = px[3*CHAN_W +: CHAN_W];
			if (d < span)
				e.alpha = feathered_alpha(px[3*CHAN_W +: CHAN_W], d, span);
			e.frame_end = (x == w - 1) && (y == h - 1);
			pending = {pending, e};
			x++;
			if (x >= w) begin
				x = 0;
				y++;
				if (y >= h)
					y = 0;
			end
			col = x;
			row = y;
		endfunction

		function void check_pixel(logic [DATA_W-1:0] px, logic last);
			pixel_t e;
			pixels_done++;
			if (pending.size() == 0) begin
				$error("unexpected result: tdata %h tlast %b", px, last);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			if (px[0*CHAN_W +: CHAN_W] !== e.blue) begin
				$error("blue_out: expected %0d, got %0d", e.blue, px[0*CHAN_W +: CHAN_W]);
				mismatches++;
			end
			if (px[1*CHAN_W +: CHAN_W] !== e.green) begin
				$error("green_out: expected %0d, got %0d", e.green, px[1*CHAN_W +: CHAN_W]);
				mismatches++;
			end
			if (px[2*CHAN_W +: CHAN_W] !== e.red) begin
				$error("red_out: expected %0d, got %0d", e.red, px[2*CHAN_W +: CHAN_W]);
				mismatches++;
			end
			if (px[3*CHAN_W +: CHAN_W] !== e.alpha) begin
				$error("alpha_out: expected %0d, got %0d", e.alpha, px[3*CHAN_W +: CHAN_W]);
				mismatches++;
			end
			if (last !== e.frame_end) begin
				$error("frame_end: expected %0d, got %0d", e.frame_end, last);
				mismatches++;
			end
			if (last === 1'b1)
				frame_ends++;
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIDE_W-1:0]    cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata;   // blue_in, green_in, red_in, alpha_in
	logic                 m_tvalid;
	logic                 m_tready;
	logic [DATA_W-1:0]    m_tdata;   // blue_out, green_out, red_out, alpha_out
	logic                 m_tlast;   // frame_end

	feather_scoreboard board;
	bit                calm;          // phase with no idling on either side
	int                canvas_count;

	alpha_edge_feather dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic write_canvas(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		board.write_reg(idx, val);
	endtask

	task automatic send_pixel(logic [DATA_W-1:0] px);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = px;
		do @(posedge clk); while (!s_tready);
		board.accept_pixel(px);
	endtask

	// block is idle once every pixel has come back
	task automatic end_phase();
		int waited;
		@(negedge clk);
		s_tvalid = 1'b0;
		waited   = 0;
		while (board.pending.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] random_pixel();
		logic [DATA_W-1:0] px;
		px = $urandom;
		case ($urandom_range(0, 7))
			0, 1: px[3*CHAN_W +: CHAN_W] = '1;
			2:    px[3*CHAN_W +: CHAN_W] = '0;
			default: ;
		endcase
		return px;
	endfunction

	// mostly small canvases, some large, zero and oversize
	function automatic logic [SIDE_W-1:0] pick_side();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return SIDE_W'(MAX_SIDE_DEF);
			2:       return '1;
			3:       return SIDE_W'($urandom_range(MAX_SIDE_DEF + 1, 8190));
			4, 5:    return SIDE_W'($urandom_range(41, MAX_SIDE_DEF - 1));
			default: return SIDE_W'($urandom_range(1, 40));
		endcase
	endfunction

	initial begin
		int                remaining;
		int                n;
		int                leftover;
		logic [DATA_W-1:0] extreme_px [8];
		extreme_px   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_FFFF,
		                 32'hAAAA_AAAA, 32'h5555_5555, 32'h8080_8080, 32'h7F7F_7F7F};
		arst_n       = 1'b0;
		cfg_wen      = 1'b0;
		cfg_index    = REG_CANVAS_WIDTH;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		calm         = 1'b0;
		canvas_count = 1;
		board        = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset canvas, channel extremes
		foreach (extreme_px[i])
			send_pixel(extreme_px[i]);
		end_phase();

		// zero sizes act as one: every pixel ends a frame
		write_canvas(REG_CANVAS_WIDTH, '0);
		write_canvas(REG_CANVAS_HEIGHT, '0);
		canvas_count++;
		repeat (3) send_pixel(random_pixel());
		end_phase();

		// oversize width clamps to the max side
		write_canvas(REG_CANVAS_WIDTH, '1);
		write_canvas(REG_CANVAS_HEIGHT, SIDE_W'(2));
		canvas_count++;
		repeat (4) send_pixel({8'hFF, 24'($urandom)});
		end_phase();

		// rewriting the same width mid-frame restarts at pixel 0
		write_canvas(REG_CANVAS_WIDTH, SIDE_W'(5));
		write_canvas(REG_CANVAS_HEIGHT, SIDE_W'(3));
		canvas_count++;
		repeat (4) send_pixel(random_pixel());
		end_phase();
		write_canvas(REG_CANVAS_WIDTH, SIDE_W'(5));
		repeat (4) send_pixel(random_pixel());
		end_phase();

		remaining = 1350;
		while (remaining > 0) begin
			case ($urandom_range(0, 3))
				0: write_canvas(REG_CANVAS_WIDTH, pick_side());
				1: write_canvas(REG_CANVAS_HEIGHT, pick_side());
				default: begin
					if ($urandom_range(0, 1)) begin
						write_canvas(REG_CANVAS_WIDTH, pick_side());
						write_canvas(REG_CANVAS_HEIGHT, pick_side());
					end else begin
						write_canvas(REG_CANVAS_HEIGHT, pick_side());
						write_canvas(REG_CANVAS_WIDTH, pick_side());
					end
				end
			endcase
			canvas_count++;
			calm = ($urandom_range(0, 3) == 0);
			n    = $urandom_range(10, 120);
			if (n > remaining)
				n = remaining;
			repeat (n) send_pixel(random_pixel());
			remaining -= n;
			end_phase();
		end

		leftover = board.pending.size();
		if (leftover != 0)
			$error("%0d expected pixels never returned", leftover);
		$display("Checked %0d pixels over %0d canvas settings, %0d frame ends seen",
		         board.pixels_done, canvas_count, board.frame_ends);
		if (board.mismatches == 0 && leftover == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side: random backpressure
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_pixel(m_tdata, m_tlast);
		end
	end

	initial begin
		#1_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/aef_pkg.sv
sv/aef_ctrl.sv
sv/aef_dpath.sv
sv/alpha_edge_feather.sv
sv/aef_checker.sv
tb/alpha_edge_feather_test.sv
